// ----- sv/evolutionary_parent_selector_unit_defines.svh -----
// Assertion macros for the parent selector unit.
// Depends on nothing; users must have clk_i and rst_ni in scope.
`ifndef EVOLUTIONARY_PARENT_SELECTOR_UNIT_DEFINES_SVH
`define EVOLUTIONARY_PARENT_SELECTOR_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset
`define EPS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("eps: assertion failed");
// Check that a condition never holds outside reset
`define EPS_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("eps: forbidden condition seen");
`else
`define EPS_ASSERT(lbl, prop)
`define EPS_ASSERT_NEVER(lbl, cond)
`endif
`endif

// ----- sv/eps_pkg.sv -----
// Shared types and constants of the parent selector unit.
// Used by the controller, the datapath and the top level.
package eps_pkg;

  localparam int FIT_W     = 32;
  localparam int RAND_W    = 32;
  localparam int OUT_CNT_W = 5;

  typedef enum logic [1:0] {
    ACT_STORE  = 2'd0,
    ACT_CLEAR  = 2'd1,
    ACT_SELECT = 2'd2,
    ACT_NONE   = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    MODE_BEST   = 2'd0,
    MODE_RANK   = 2'd1,
    MODE_TOURN  = 2'd2,
    MODE_RANDOM = 2'd3
  } mode_e;

  // Divider operand choice: first word by count, second word by count
  // minus one, first word by triangular total
  typedef enum logic [1:0] {
    DIV_FIRST  = 2'd0,
    DIV_SECOND = 2'd1,
    DIV_TOTAL  = 2'd2
  } div_sel_e;

  typedef struct packed {
    logic     load;
    logic     clear;
    logic     scan_init;
    logic     scan_run;
    logic     rank_next;
    logic     shift_init;
    logic     shift_run;
    logic     put;
    logic     div_start;
    div_sel_e div_sel;
    logic     div_cap;
    div_sel_e cap_sel;
    logic     walk_run;
    logic     zero_a;
    logic     fetch_a;
    logic     fetch_b;
    logic     judge;
  } cmd_t;

  typedef struct packed {
    act_e  act;
    mode_e mode;
    logic  empty;
    logic  single;
    logic  full;
    logic  hit;
    logic  scan_done;
    logic  shift_done;
    logic  walk_done;
    logic  rank_last;
    logic  div_done;
  } stat_t;

endpackage

// ----- sv/eps_divider.sv -----
// Restoring remainder unit, one dividend bit per cycle.
// Depends on eps_pkg for the dividend width.
module eps_divider #(
  parameter int DVS_W = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [eps_pkg::RAND_W-1:0] dividend_i,
  input  logic [DVS_W-1:0]         divisor_i,
  output logic                     done_o,
  output logic [DVS_W-1:0]         rem_o
);

  localparam int CNT_W = $clog2(eps_pkg::RAND_W + 1);

  logic                       busy_q;
  logic                       done_q;
  logic [CNT_W-1:0]           cnt_q;
  logic [DVS_W-1:0]           rem_q;
  logic [DVS_W-1:0]           dvs_q;
  logic [eps_pkg::RAND_W-1:0] quo_q;
  logic [DVS_W:0]             shifted;
  logic [DVS_W:0]             diff;
  logic [DVS_W-1:0]           rem_d;

  // Bring down the next dividend bit and subtract when it fits
  always_comb begin
    shifted = {rem_q, quo_q[eps_pkg::RAND_W-1]};
    diff    = shifted - {1'b0, dvs_q};
    if (shifted >= {1'b0, dvs_q}) begin
      rem_d = diff[DVS_W-1:0];
    end else begin
      rem_d = shifted[DVS_W-1:0];
    end
  end

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(eps_pkg::RAND_W);
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Partial remainder and dividend shift
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[eps_pkg::RAND_W-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ----- sv/eps_dpath.sv -----
// Datapath of the parent selector: entry memory, scan accumulators,
// rank walk, tournament picks and the remainder unit. Uses eps_pkg.
`include "evolutionary_parent_selector_unit_defines.svh"
module eps_dpath #(
  parameter int MAX_ENTRIES = 16,
  parameter int KEY_BITS    = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_data_i,
  input  logic [1:0]                    action_i,
  input  logic [KEY_BITS-1:0]           entry_key_i,
  input  logic [eps_pkg::FIT_W-1:0]     entry_fitness_i,
  input  logic [eps_pkg::RAND_W-1:0]    rand_first_i,
  input  logic [eps_pkg::RAND_W-1:0]    rand_second_i,
  input  eps_pkg::cmd_t                 cmd_i,
  output eps_pkg::stat_t                stat_o,
  output logic [KEY_BITS-1:0]           chosen_key_o,
  output logic                          chosen_valid_o,
  output logic [eps_pkg::OUT_CNT_W-1:0] entry_count_o
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int TOT_W = $clog2(MAX_ENTRIES * (MAX_ENTRIES + 1) / 2 + 1);
  localparam int FIT_W = eps_pkg::FIT_W;

  // Entry store
  logic [KEY_BITS-1:0] key_mem [MAX_ENTRIES];
  logic [FIT_W-1:0]    fit_mem [MAX_ENTRIES];
  logic [KEY_BITS-1:0] rd_key_q;
  logic [FIT_W-1:0]    rd_fit_q;
  logic [IDX_W-1:0]    rd_addr;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [KEY_BITS-1:0] wr_key;
  logic [FIT_W-1:0]    wr_fit;

  // Control state
  eps_pkg::mode_e mode_q;
  logic [CNT_W-1:0] cnt_q;
  logic             rd_vld_q;

  // Item and working registers
  eps_pkg::act_e              act_q;
  logic [KEY_BITS-1:0]        key_q;
  logic [FIT_W-1:0]           fit_q;
  logic [eps_pkg::RAND_W-1:0] r1_q;
  logic [eps_pkg::RAND_W-1:0] r2_q;
  logic                       res_valid_q;
  logic [IDX_W-1:0]           rd_idx_q;
  logic [CNT_W-1:0]           idx_q;
  logic [CNT_W-1:0]           sh_q;
  logic [CNT_W-1:0]           pos_q;
  logic                       found_q;
  logic                       hit_q;
  logic [FIT_W-1:0]           best_fit_q;
  logic [KEY_BITS-1:0]        best_key_q;
  logic [IDX_W-1:0]           best_idx_q;
  logic [FIT_W-1:0]           prev_fit_q;
  logic [IDX_W-1:0]           prev_idx_q;
  logic [CNT_W-1:0]           pass_q;
  logic [CNT_W-1:0]           target_q;
  logic [CNT_W-1:0]           step_q;
  logic [TOT_W-1:0]           rr_q;
  logic [IDX_W-1:0]           a_q;
  logic [IDX_W-1:0]           b_q;
  logic [KEY_BITS-1:0]        fa_key_q;
  logic [FIT_W-1:0]           fa_fit_q;

  // Combinational helpers
  logic [CNT_W-1:0]           sh_m1;
  logic [IDX_W-1:0]           rd_nx;
  logic [IDX_W-1:0]           rd_idx_d;
  logic                       rd_vld_d;
  logic [CNT_W:0]             n_plus1;
  logic [2*CNT_W:0]           tri_prod;
  logic [TOT_W-1:0]           tri_total;
  logic                       div_start;
  logic [eps_pkg::RAND_W-1:0] div_dividend;
  logic [TOT_W-1:0]           div_divisor;
  logic                       div_done;
  logic [TOT_W-1:0]           div_rem;
  logic [IDX_W-1:0]           rem_idx;
  logic                       walk_done;
  logic                       gt_prev;
  logic                       take_best;
  logic                       take_rank;
  logic                       a_wins;

  assign sh_m1    = sh_q - CNT_W'(1);
  assign rd_nx    = IDX_W'({1'b0, rd_idx_q} + (IDX_W + 1)'(1));
  assign rem_idx  = div_rem[IDX_W-1:0];
  assign walk_done = !(rr_q > TOT_W'(step_q));

  // Triangular total n(n+1)/2 for the rank draw
  assign n_plus1   = {1'b0, cnt_q} + (CNT_W + 1)'(1);
  assign tri_prod  = {{(CNT_W + 1){1'b0}}, cnt_q} * {{CNT_W{1'b0}}, n_plus1};
  assign tri_total = TOT_W'(tri_prod >> 1);

  // Pick divider operands
  always_comb begin
    div_start    = cmd_i.div_start;
    div_dividend = r1_q;
    div_divisor  = TOT_W'(cnt_q);
    case (cmd_i.div_sel)
      eps_pkg::DIV_FIRST: begin
        div_dividend = r1_q;
        div_divisor  = TOT_W'(cnt_q);
      end
      eps_pkg::DIV_SECOND: begin
        div_dividend = r2_q;
        div_divisor  = TOT_W'(cnt_q - CNT_W'(1));
      end
      eps_pkg::DIV_TOTAL: begin
        div_dividend = r1_q;
        div_divisor  = tri_total;
      end
      default: begin
        div_dividend = r1_q;
        div_divisor  = TOT_W'(cnt_q);
      end
    endcase
  end

  eps_divider #(
    .DVS_W(TOT_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .rem_o     (div_rem)
  );

  // Memory address and write selection
  always_comb begin
    if (cmd_i.fetch_a) begin
      rd_addr = a_q;
    end else if (cmd_i.fetch_b) begin
      rd_addr = b_q;
    end else if (cmd_i.shift_run) begin
      rd_addr = sh_m1[IDX_W-1:0];
    end else begin
      rd_addr = idx_q[IDX_W-1:0];
    end
    rd_idx_d = cmd_i.shift_run ? sh_m1[IDX_W-1:0] : idx_q[IDX_W-1:0];
    rd_vld_d = (cmd_i.scan_run && (idx_q < cnt_q)) ||
               (cmd_i.shift_run && (sh_q > pos_q));
    wr_en    = cmd_i.put || (cmd_i.shift_run && rd_vld_q);
    if (cmd_i.put) begin
      wr_addr = pos_q[IDX_W-1:0];
      wr_key  = key_q;
      wr_fit  = fit_q;
    end else begin
      wr_addr = rd_nx;
      wr_key  = rd_key_q;
      wr_fit  = rd_fit_q;
    end
  end

  // Entry store with registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      fit_mem[wr_addr] <= wr_fit;
    end
    rd_key_q <= key_mem[rd_addr];
    rd_fit_q <= fit_mem[rd_addr];
  end

  // Scan decisions
  always_comb begin
    gt_prev   = (pass_q == '0) || (rd_fit_q > prev_fit_q) ||
                ((rd_fit_q == prev_fit_q) && (rd_idx_q > prev_idx_q));
    take_best = !found_q || (rd_fit_q > best_fit_q);
    take_rank = gt_prev && (!found_q || (rd_fit_q < best_fit_q));
    a_wins    = (mode_q != eps_pkg::MODE_TOURN) || (cnt_q < CNT_W'(2)) ||
                (fa_fit_q >= rd_fit_q);
  end

  // Control registers: mode, count, read pipeline flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= eps_pkg::MODE_BEST;
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= eps_pkg::mode_e'(cfg_data_i);
      end
      if (cmd_i.clear) begin
        cnt_q <= '0;
      end else if (cmd_i.put && !hit_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      rd_vld_q <= rd_vld_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    // hold the item
    if (cmd_i.load) begin
      act_q       <= eps_pkg::act_e'(action_i);
      key_q       <= entry_key_i;
      fit_q       <= entry_fitness_i;
      r1_q        <= rand_first_i;
      r2_q        <= rand_second_i;
      res_valid_q <= (eps_pkg::act_e'(action_i) == eps_pkg::ACT_SELECT) &&
                     (cnt_q != '0);
      best_key_q  <= '0;
    end
    rd_idx_q <= rd_idx_d;

    // advance the scan and fold in each returned word
    if (cmd_i.scan_run) begin
      if (idx_q < cnt_q) begin
        idx_q <= idx_q + CNT_W'(1);
      end
      if (rd_vld_q) begin
        if (act_q == eps_pkg::ACT_STORE) begin
          if (!found_q && (rd_key_q >= key_q)) begin
            found_q <= 1'b1;
            pos_q   <= CNT_W'(rd_idx_q);
            hit_q   <= (rd_key_q == key_q);
          end
        end else if ((mode_q == eps_pkg::MODE_RANK) ? take_rank : take_best) begin
          found_q    <= 1'b1;
          best_fit_q <= rd_fit_q;
          best_key_q <= rd_key_q;
          best_idx_q <= rd_idx_q;
        end
      end
    end
    if (cmd_i.scan_init) begin
      idx_q   <= '0;
      found_q <= 1'b0;
      hit_q   <= 1'b0;
      pos_q   <= cnt_q;
      pass_q  <= '0;
    end
    if (cmd_i.rank_next) begin
      idx_q      <= '0;
      found_q    <= 1'b0;
      pass_q     <= pass_q + CNT_W'(1);
      prev_fit_q <= best_fit_q;
      prev_idx_q <= best_idx_q;
    end

    // walk down the insertion gap
    if (cmd_i.shift_init) begin
      sh_q <= cnt_q;
    end else if (cmd_i.shift_run && (sh_q > pos_q)) begin
      sh_q <= sh_m1;
    end

    // take divider results
    if (cmd_i.div_cap) begin
      case (cmd_i.cap_sel)
        eps_pkg::DIV_FIRST: begin
          a_q <= rem_idx;
        end
        eps_pkg::DIV_SECOND: begin
          b_q <= (rem_idx >= a_q) ? rem_idx + IDX_W'(1) : rem_idx;
        end
        eps_pkg::DIV_TOTAL: begin
          rr_q     <= div_rem + TOT_W'(1);
          step_q   <= CNT_W'(1);
          target_q <= '0;
        end
        default: begin
          a_q <= rem_idx;
        end
      endcase
    end
    if (cmd_i.zero_a) begin
      a_q <= '0;
    end

    // use up the draw one rank at a time
    if (cmd_i.walk_run && !walk_done) begin
      rr_q     <= rr_q - TOT_W'(step_q);
      step_q   <= step_q + CNT_W'(1);
      target_q <= target_q + CNT_W'(1);
    end

    // hold contestant a, then judge against b
    if (cmd_i.fetch_b) begin
      fa_key_q <= rd_key_q;
      fa_fit_q <= rd_fit_q;
    end
    if (cmd_i.judge) begin
      best_key_q <= a_wins ? fa_key_q : rd_key_q;
    end
  end

  // Status to the controller
  always_comb begin
    stat_o            = '0;
    stat_o.act        = act_q;
    stat_o.mode       = mode_q;
    stat_o.empty      = (cnt_q == '0);
    stat_o.single     = (cnt_q == CNT_W'(1));
    stat_o.full       = (cnt_q == CNT_W'(MAX_ENTRIES));
    stat_o.hit        = hit_q;
    stat_o.scan_done  = (idx_q == cnt_q) && !rd_vld_q;
    stat_o.shift_done = (sh_q == pos_q) && !rd_vld_q;
    stat_o.walk_done  = walk_done;
    stat_o.rank_last  = (pass_q == target_q);
    stat_o.div_done   = div_done;
  end

  assign chosen_key_o   = res_valid_q ? best_key_q : '0;
  assign chosen_valid_o = res_valid_q;
  assign entry_count_o  = eps_pkg::OUT_CNT_W'(cnt_q);

  `EPS_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(MAX_ENTRIES))
  `EPS_ASSERT(a_put_room, (cmd_i.put && !hit_q) |-> (cnt_q < CNT_W'(MAX_ENTRIES)))
  `EPS_ASSERT(a_shift_addr, (cmd_i.shift_run && rd_vld_q) |-> ({1'b0, rd_idx_q} < cnt_q))
  `EPS_ASSERT(a_rank_target, (cmd_i.walk_run && walk_done) |-> (target_q < cnt_q))
  `EPS_ASSERT_NEVER(a_pass_over, cmd_i.rank_next && (pass_q >= target_q))

endmodule

// ----- sv/eps_ctrl.sv -----
// Controller of the parent selector: sequences each word through the
// datapath by command and status structs. Uses eps_pkg.
module eps_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  eps_pkg::stat_t stat_i,
  output eps_pkg::cmd_t  cmd_o,
  output logic           busy_o,
  output logic           done_o
);

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_DISPATCH = 13'b0000000000010,
    S_DIV_A    = 13'b0000000000100,
    S_DIV_B    = 13'b0000000001000,
    S_DIV_T    = 13'b0000000010000,
    S_WALK     = 13'b0000000100000,
    S_SCAN     = 13'b0000001000000,
    S_SHIFT    = 13'b0000010000000,
    S_PUT      = 13'b0000100000000,
    S_FETCH_A  = 13'b0001000000000,
    S_FETCH_B  = 13'b0010000000000,
    S_JUDGE    = 13'b0100000000000,
    S_RESP     = 13'b1000000000000
  } state_e;

  state_e state_q;
  state_e state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat_i.act)
          eps_pkg::ACT_STORE: begin
            cmd_o.scan_init = 1'b1;
            state_d         = S_SCAN;
          end
          eps_pkg::ACT_CLEAR: begin
            cmd_o.clear = 1'b1;
            state_d     = S_RESP;
          end
          eps_pkg::ACT_SELECT: begin
            if (stat_i.empty) begin
              state_d = S_RESP;
            end else begin
              case (stat_i.mode)
                eps_pkg::MODE_BEST: begin
                  cmd_o.scan_init = 1'b1;
                  state_d         = S_SCAN;
                end
                eps_pkg::MODE_RANK: begin
                  cmd_o.div_start = 1'b1;
                  cmd_o.div_sel   = eps_pkg::DIV_TOTAL;
                  state_d         = S_DIV_T;
                end
                eps_pkg::MODE_TOURN: begin
                  if (stat_i.single) begin
                    cmd_o.zero_a = 1'b1;
                    state_d      = S_FETCH_A;
                  end else begin
                    cmd_o.div_start = 1'b1;
                    cmd_o.div_sel   = eps_pkg::DIV_FIRST;
                    state_d         = S_DIV_A;
                  end
                end
                default: begin
                  cmd_o.div_start = 1'b1;
                  cmd_o.div_sel   = eps_pkg::DIV_FIRST;
                  state_d         = S_DIV_A;
                end
              endcase
            end
          end
          default: begin
            state_d = S_RESP;
          end
        endcase
      end
      S_DIV_A: begin
        cmd_o.div_sel = eps_pkg::DIV_FIRST;
        if (stat_i.div_done) begin
          cmd_o.div_cap = 1'b1;
          cmd_o.cap_sel = eps_pkg::DIV_FIRST;
          if (stat_i.mode == eps_pkg::MODE_TOURN) begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_sel   = eps_pkg::DIV_SECOND;
            state_d         = S_DIV_B;
          end else begin
            state_d = S_FETCH_A;
          end
        end
      end
      S_DIV_B: begin
        if (stat_i.div_done) begin
          cmd_o.div_cap = 1'b1;
          cmd_o.cap_sel = eps_pkg::DIV_SECOND;
          state_d       = S_FETCH_A;
        end
      end
      S_DIV_T: begin
        if (stat_i.div_done) begin
          cmd_o.div_cap = 1'b1;
          cmd_o.cap_sel = eps_pkg::DIV_TOTAL;
          state_d       = S_WALK;
        end
      end
      S_WALK: begin
        cmd_o.walk_run = 1'b1;
        if (stat_i.walk_done) begin
          cmd_o.scan_init = 1'b1;
          state_d         = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (stat_i.scan_done) begin
          if (stat_i.act == eps_pkg::ACT_STORE) begin
            if (stat_i.hit) begin
              state_d = S_PUT;
            end else if (stat_i.full) begin
              state_d = S_RESP;
            end else begin
              cmd_o.shift_init = 1'b1;
              state_d          = S_SHIFT;
            end
          end else if ((stat_i.mode == eps_pkg::MODE_RANK) && !stat_i.rank_last) begin
            cmd_o.rank_next = 1'b1;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_SHIFT: begin
        cmd_o.shift_run = 1'b1;
        if (stat_i.shift_done) begin
          state_d = S_PUT;
        end
      end
      S_PUT: begin
        cmd_o.put = 1'b1;
        state_d   = S_RESP;
      end
      S_FETCH_A: begin
        cmd_o.fetch_a = 1'b1;
        state_d       = S_FETCH_B;
      end
      S_FETCH_B: begin
        cmd_o.fetch_b = 1'b1;
        state_d       = S_JUDGE;
      end
      S_JUDGE: begin
        cmd_o.judge = 1'b1;
        state_d     = S_RESP;
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_RESP);

endmodule

// ----- sv/evolutionary_parent_selector_unit.sv -----
// Top level of the parent selector: controller plus datapath.
// Depends on eps_pkg, eps_ctrl, eps_dpath and eps_divider.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------
//  command  | start_i, busy_o            | action, entry_key, entry_fitness,
//           |                            | rand_first, rand_second
//  result   | done_o (one-cycle strobe)  | chosen_key, chosen_valid,
//           |                            | entry_count
//  config   | cfg_valid_i, cfg_ready_o   | cfg_data_i (selection mode)
//
// One word at a time; busy_o stays high from acceptance until the done_o cycle.
// With n entries held, store scans the n keys, then on a key hit writes in
// place, or with room on an insert shifts the larger entries one per cycle
// through the single port and writes. Select: best scans all entries; random
// runs the 32-step remainder unit once and tournament twice; rank runs it on
// the triangular total, walks to rank t and scans t + 1 times; a tournament
// over one entry skips it. Empty select, clear and unknown actions go to S_RESP.
// Reset empties the table at once. The result receiver cannot stall; config is
// ready only while idle with no word offered.
module evolutionary_parent_selector_unit #(
  parameter int MAX_ENTRIES = 16,
  parameter int KEY_BITS    = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    action_i,
  input  logic [KEY_BITS-1:0]           entry_key_i,
  input  logic [eps_pkg::FIT_W-1:0]     entry_fitness_i,
  input  logic [eps_pkg::RAND_W-1:0]    rand_first_i,
  input  logic [eps_pkg::RAND_W-1:0]    rand_second_i,
  output logic                          done_o,
  output logic [KEY_BITS-1:0]           chosen_key_o,
  output logic                          chosen_valid_o,
  output logic [eps_pkg::OUT_CNT_W-1:0] entry_count_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_data_i
);

  eps_pkg::cmd_t  cmd;
  eps_pkg::stat_t stat;
  logic           busy;

  // Take config only while no word is in flight or offered
  assign cfg_ready_o = !busy && !start_i;
  assign busy_o      = busy;

  eps_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i && !busy),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy),
    .done_o (done_o)
  );

  eps_dpath #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .KEY_BITS   (KEY_BITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .action_i       (action_i),
    .entry_key_i    (entry_key_i),
    .entry_fitness_i(entry_fitness_i),
    .rand_first_i   (rand_first_i),
    .rand_second_i  (rand_second_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .chosen_key_o   (chosen_key_o),
    .chosen_valid_o (chosen_valid_o),
    .entry_count_o  (entry_count_o)
  );

endmodule

// ----- verif/tb.sv -----
// Testbench for the parent selector: directed and random command words
// checked against an in-bench predictor of the candidate table.
// Depends on eps_pkg and evolutionary_parent_selector_unit.
`timescale 1ns / 100ps

module tb;

  localparam int N_SLOTS = 16;
  localparam int KEY_W = 8;
  localparam int LIMIT = 2000000;

  typedef struct {
    logic [KEY_W-1:0] key;
    logic             valid;
    logic [4:0]       count;
  } pick_t;

  // Candidate table predictor and store of pending picks
  class parent_scoreboard;
    logic [KEY_W-1:0] keys[N_SLOTS];
    logic [31:0]      fits[N_SLOTS];
    int               held;
    eps_pkg::mode_e   mode;
    pick_t            pending[$];
    int               errors;

    function void reset_state();
      held = 0;
      mode = eps_pkg::MODE_BEST;
    endfunction

    function void add_entry(logic [KEY_W-1:0] k, logic [31:0] f);
      int pos;
      pos = 0;
      while (pos < held && keys[pos] < k) pos++;
      if (pos < held && keys[pos] == k) begin
        fits[pos] = f;
        return;
      end
      if (held >= N_SLOTS) return;
      for (int i = held; i > pos; i--) begin
        keys[i] = keys[i-1];
        fits[i] = fits[i-1];
      end
      keys[pos] = k;
      fits[pos] = f;
      held++;
    endfunction

    function int rank_pick(logic [31:0] r1);
      longint unsigned total, r, stp;
      int target, rank;
      total = held * (held + 1) / 2;
      r = r1 % total + 1;
      stp = 1;
      target = 0;
      while (r > stp) begin
        r -= stp;
        stp++;
        target++;
      end
      for (int i = 0; i < held; i++) begin
        rank = 0;
        for (int j = 0; j < held; j++)
          if (fits[j] < fits[i] || (fits[j] == fits[i] && j < i)) rank++;
        if (rank == target) return i;
      end
      return 0;
    endfunction

    // Note an accepted command word and queue its expected answer
    function void note_command(eps_pkg::act_e act, logic [KEY_W-1:0] k, logic [31:0] f,
                               logic [31:0] r1, logic [31:0] r2);
      pick_t p;
      int pos, a, b;
      p.key = '0;
      p.valid = 1'b0;
      if (act == eps_pkg::ACT_STORE) add_entry(k, f);
      else if (act == eps_pkg::ACT_CLEAR) held = 0;
      else if (act == eps_pkg::ACT_SELECT && held > 0) begin
        case (mode)
          eps_pkg::MODE_BEST: begin
            pos = 0;
            for (int i = 1; i < held; i++) if (fits[i] > fits[pos]) pos = i;
          end
          eps_pkg::MODE_RANK: pos = rank_pick(r1);
          eps_pkg::MODE_TOURN: begin
            if (held < 2) pos = 0;
            else begin
              a = r1 % held;
              b = r2 % (held - 1);
              if (b >= a) b++;
              pos = (fits[a] >= fits[b]) ? a : b;
            end
          end
          default: pos = r1 % held;
        endcase
        p.key = keys[pos];
        p.valid = 1'b1;
      end
      p.count = held[4:0];
      pending = {pending, p};
    endfunction

    task report(string what);
      $display("%0t: %s", $realtime, what);
      errors++;
    endtask

    // Compare one result word against the oldest expectation
    task check_result(logic [KEY_W-1:0] k, logic v, logic [4:0] c);
      pick_t p;
      if (pending.size() == 0) begin
        report("unexpected result word");
        return;
      end
      p = pending.pop_front();
      if (k !== p.key) report($sformatf("chosen_key %0h, want %0h", k, p.key));
      if (v !== p.valid) report($sformatf("chosen_valid %0b, want %0b", v, p.valid));
      if (c !== p.count) report($sformatf("entry_count %0d, want %0d", c, p.count));
    endtask
  endclass

  logic clk_i, rst_ni, start_i, busy_o, done_o;
  logic [1:0] action_i;
  logic [KEY_W-1:0] entry_key_i;
  logic [31:0] entry_fitness_i, rand_first_i, rand_second_i;
  logic [KEY_W-1:0] chosen_key_o;
  logic chosen_valid_o;
  logic [4:0] entry_count_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [1:0] cfg_data_i;
  int cycles = 0;
  parent_scoreboard sb;

  evolutionary_parent_selector_unit dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog on total run length
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("evolutionary_parent_selector_unit: mismatch");
      $finish;
    end
  end

  // Results cannot be held off: check every strobed word
  always @(posedge clk_i)
    if (rst_ni && done_o) sb.check_result(chosen_key_o, chosen_valid_o, entry_count_o);

  task idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    repeat (n) @(posedge clk_i);
  endtask

  // Drive one command word and hold until accepted
  task send_word(eps_pkg::act_e act, logic [KEY_W-1:0] k, logic [31:0] f,
                 logic [31:0] r1, logic [31:0] r2);
    start_i <= 1'b1;
    action_i <= act;
    entry_key_i <= k;
    entry_fitness_i <= f;
    rand_first_i <= r1;
    rand_second_i <= r2;
    do @(posedge clk_i); while (busy_o);
    sb.note_command(act, k, f, r1, r2);
    start_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write the mode register while the block is idle
  task write_mode(eps_pkg::mode_e m);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.mode = m;
    cfg_valid_i <= 1'b0;
  endtask

  function logic [31:0] rand_fit();
    case ($urandom_range(0, 4))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  task random_word(int key_span);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55)
      send_word(eps_pkg::ACT_STORE, KEY_W'($urandom_range(0, key_span)), rand_fit(),
                $urandom, $urandom);
    else if (roll < 58)
      send_word(eps_pkg::ACT_CLEAR, KEY_W'($urandom), $urandom, $urandom, $urandom);
    else if (roll < 60)
      send_word(eps_pkg::ACT_NONE, KEY_W'($urandom), $urandom, $urandom, $urandom);
    else send_word(eps_pkg::ACT_SELECT, KEY_W'($urandom), $urandom, $urandom, $urandom);
    idle_gap();
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    sb.errors = 0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    action_i = eps_pkg::ACT_STORE;
    entry_key_i = '0;
    entry_fitness_i = '0;
    rand_first_i = '0;
    rand_second_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = eps_pkg::MODE_BEST;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty select, extremes, overwrite, full table, unknown action
    send_word(eps_pkg::ACT_SELECT, 8'h00, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(eps_pkg::ACT_STORE, 8'hFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
    write_mode(eps_pkg::MODE_TOURN);
    send_word(eps_pkg::ACT_SELECT, 8'h00, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(eps_pkg::ACT_STORE, 8'h00, 32'h0, 32'h0, 32'h0);
    send_word(eps_pkg::ACT_STORE, 8'hFF, 32'h1, 32'h0, 32'h0);
    send_word(eps_pkg::ACT_NONE, 8'h55, 32'hAAAA_5555, 32'h0, 32'h0);
    for (int i = 0; i < 17; i++)
      send_word(eps_pkg::ACT_STORE, KEY_W'(8'h10 + i * 7), i % 3, 32'h0, 32'h0);
    for (int m = 0; m < 4; m++) begin
      write_mode(eps_pkg::mode_e'(m));
      send_word(eps_pkg::ACT_SELECT, 8'h00, 32'h0, 32'hFFFF_FFFF, 32'h0);
      send_word(eps_pkg::ACT_SELECT, 8'hFF, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    end
    send_word(eps_pkg::ACT_CLEAR, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // Random phases across all modes, mostly small key spans to fill and hit
    for (int ph = 0; ph < 13; ph++) begin
      write_mode(eps_pkg::mode_e'($urandom_range(0, 3)));
      for (int i = 0; i < 100; i++) random_word(ph % 3 == 0 ? 255 : 20);
      if (ph == 6) drain();
    end
    write_mode(eps_pkg::MODE_RANDOM);
    write_mode(eps_pkg::MODE_BEST);
    drain();
    repeat (100) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("evolutionary_parent_selector_unit: match");
    else
      $display("evolutionary_parent_selector_unit: mismatch");
    $finish;
  end
endmodule
